/* rtl/lpht_pkg.sv */
package lpht_pkg;

  localparam int MOD_W  = 7;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;
  localparam int KEY_W  = 64;

  localparam logic [MOD_W-1:0] MOD_RESET = 7'd61;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_DIV,
    OP_WRAP,
    OP_HOME,
    OP_PROBE,
    OP_FINISH,
    OP_FAIL,
    OP_REJECT
  } op_t;

  // sequencer conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_KEY_ZERO,
    C_CNT_MORE,
    C_HIT,
    C_PROBE_MORE,
    C_CLR_MORE
  } cond_t;

  // program steps
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ZCHK,
    S_DIV1,
    S_WRAP,
    S_HOME,
    S_PROBE,
    S_FAIL,
    S_DONE,
    S_REJ
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t jmp;     // jump to target when true
    step_t target;
    cond_t hold;    // else repeat this step when true
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      S_CLEAR: w = '{OP_CLEAR,  C_NEVER,    S_IDLE,  C_CLR_MORE};
      S_IDLE:  w = '{OP_ACCEPT, C_NEVER,    S_IDLE,  C_NO_START};
      S_ZCHK:  w = '{OP_NOP,    C_KEY_ZERO, S_REJ,   C_NEVER};
      S_DIV1:  w = '{OP_DIV,    C_NEVER,    S_IDLE,  C_CNT_MORE};
      S_WRAP:  w = '{OP_WRAP,   C_NEVER,    S_IDLE,  C_NEVER};
      S_HOME:  w = '{OP_HOME,   C_NEVER,    S_IDLE,  C_NEVER};
      S_PROBE: w = '{OP_PROBE,  C_HIT,      S_DONE,  C_PROBE_MORE};
      S_FAIL:  w = '{OP_FAIL,   C_ALWAYS,   S_IDLE,  C_NEVER};
      S_DONE:  w = '{OP_FINISH, C_ALWAYS,   S_IDLE,  C_NEVER};
      S_REJ:   w = '{OP_REJECT, C_ALWAYS,   S_IDLE,  C_NEVER};
      default: w = '{OP_NOP,    C_ALWAYS,   S_IDLE,  C_NEVER};
    endcase
    return w;
  endfunction

endpackage

/* rtl/lpht_ram.sv */
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/linear_probe_hash_table_top.sv */
// Open-addressing hash table with linear probing, driven by a small microcoded
// sequencer. A transaction is accepted at a clock edge with start high and busy
// low; its one result appears on out_status/out_slot for exactly one cycle with
// out_valid high, and the receiver cannot hold it off. After reset the block
// sweeps the key store to zero, one slot per cycle, and busy stays high until
// the sweep ends. Busy then stays high through each transaction's steps: a
// check for a zero key, a bit-serial restoring division over the SUM_W bits of
// the byte sum that gives the sum mod the modulus register, a wrap of that to
// the table size through a small constant table, a read of the home slot,
// probing that checks one slot per cycle (1 to TABLE_SIZE slots) from the key
// memory, which has separate read and write ports, and a last finish step. A
// zero key goes from the check straight to a reject step. The result strobe
// falls in the first idle cycle, so a new start may be given in that same
// cycle.
module linear_probe_hash_table_top #(
  parameter int TABLE_SIZE = 64,
  parameter int KEY_CHARS  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [lpht_pkg::KEY_W-1:0]  in_key_bytes,
  output logic                        out_valid,
  output logic [lpht_pkg::STAT_W-1:0] out_status,
  output logic [lpht_pkg::SLOT_W-1:0] out_slot,
  input  logic                        cfg_we,
  input  logic [lpht_pkg::MOD_W-1:0]  cfg_wdata
);

  import lpht_pkg::*;

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int KW    = 8 * KEY_CHARS;
  localparam int SUM_W = $clog2(255 * KEY_CHARS + 1);
  localparam int DIV_W = MOD_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  // sequencer state
  step_t pc_r, pc_nxt;
  ctrl_t cw;

  // configuration
  logic [MOD_W-1:0] mod_r;

  // datapath registers
  logic             cmd_r;
  logic [KW-1:0]    key_r;
  logic [SUM_W-1:0] dvd_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    cur_r;   // probe slot, also the clear sweep address
  logic [AW-1:0]    prb_r;   // slots probed so far

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  // key store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [KW-1:0] ram_wdata, ram_rdata;

  // datapath combinational values
  logic [SUM_W-1:0]     sum_c;
  logic [MOD_W-1:0]     mod_eff;
  logic [DIV_W:0]       shifted;
  logic [DIV_W-1:0]     rem_step;
  logic [AW-1:0]        cur_inc;
  logic                 empty, match, hit;
  logic                 key_zero, cnt_more, prb_more, clr_more;
  logic [AW+SLOT_W-1:0] slot_ext;

  function automatic logic cond_true(cond_t c, logic st, logic kz, logic cm,
                                     logic ht, logic pm, logic clm);
    logic r;
    case (c)
      C_NEVER:      r = 1'b0;
      C_ALWAYS:     r = 1'b1;
      C_NO_START:   r = !st;
      C_KEY_ZERO:   r = kz;
      C_CNT_MORE:   r = cm;
      C_HIT:        r = ht;
      C_PROBE_MORE: r = pm;
      C_CLR_MORE:   r = clm;
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // remainder wrapped to the table size, a constant table over all remainders
  function automatic logic [AW-1:0] wrap_home(logic [MOD_W-1:0] r);
    logic [AW-1:0] w;
    w = '0;
    for (int v = 0; v < (1 << MOD_W); v++) begin
      if (r == MOD_W'(v)) begin
        w = AW'(v % TABLE_SIZE);
      end
    end
    return w;
  endfunction

  // byte sum over the used key characters
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      sum_c = sum_c + SUM_W'(in_key_bytes[8*i +: 8]);
    end
  end

  // a zero modulus divides by one
  assign mod_eff = (mod_r == '0) ? MOD_W'(1) : mod_r;

  // one restoring division step
  assign shifted  = {rem_r, dvd_r[SUM_W-1]};
  assign rem_step = (shifted >= {1'b0, div_r}) ? DIV_W'(shifted - {1'b0, div_r})
                                               : DIV_W'(shifted);

  // wrap at the table size
  assign cur_inc = (cur_r == AW'(TABLE_SIZE - 1)) ? '0 : cur_r + 1'b1;

  // probe decision on the slot just read
  assign empty = (ram_rdata == '0);
  assign match = (ram_rdata == key_r);
  assign hit   = (cmd_r == CMD_INSERT) ? empty : (match || empty);

  assign key_zero = (key_r == '0);
  assign cnt_more = (cnt_r != CNT_W'(1));
  assign prb_more = (prb_r != AW'(TABLE_SIZE - 1));
  assign clr_more = (cur_r != AW'(TABLE_SIZE - 1));

  assign slot_ext = {{SLOT_W{1'b0}}, cur_r};

  // fetch the control word and pick the next step
  always_comb begin
    cw = ucode(pc_r);
    if (cond_true(cw.jmp, start, key_zero, cnt_more, hit, prb_more, clr_more)) begin
      pc_nxt = cw.target;
    end else if (cond_true(cw.hold, start, key_zero, cnt_more, hit, prb_more,
                           clr_more)) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // key store access per operation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_inc;
    case (cw.op)
      OP_CLEAR: begin
        ram_we = 1'b1;
      end
      OP_HOME: begin
        ram_re    = 1'b1;
        ram_raddr = cur_r;
      end
      OP_PROBE: begin
        ram_re = !hit;
      end
      OP_FINISH: begin
        ram_we    = (cmd_r == CMD_INSERT);
        ram_wdata = key_r;
      end
      default: begin
      end
    endcase
  end

  lpht_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  // control-side datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cw.op == OP_FINISH) || (cw.op == OP_FAIL) ||
                     (cw.op == OP_REJECT);
      case (cw.op)
        OP_CLEAR: cur_r <= cur_inc;
        OP_WRAP:  cur_r <= wrap_home(rem_r);
        OP_PROBE: begin
          if (!hit) begin
            cur_r <= cur_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload datapath registers
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        // latched every idle cycle, only the accepted transaction matters
        cmd_r <= in_cmd;
        key_r <= in_key_bytes[KW-1:0];
        dvd_r <= sum_c;
        rem_r <= '0;
        div_r <= DIV_W'(mod_eff);
        cnt_r <= CNT_W'(SUM_W);
      end
      OP_DIV: begin
        rem_r <= rem_step;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end
      OP_HOME: begin
        prb_r <= '0;
      end
      OP_PROBE: begin
        if (!hit) begin
          prb_r <= prb_r + 1'b1;
        end
      end
      OP_FINISH: begin
        if ((cmd_r == CMD_LOOKUP) && empty) begin
          out_status_r <= ST_MISS;
          out_slot_r   <= '0;
        end else begin
          out_status_r <= ST_OK;
          out_slot_r   <= slot_ext[SLOT_W-1:0];
        end
      end
      OP_FAIL: begin
        out_status_r <= (cmd_r == CMD_INSERT) ? ST_FULL : ST_MISS;
        out_slot_r   <= '0;
      end
      OP_REJECT: begin
        out_status_r <= ST_ZERO;
        out_slot_r   <= '0;
      end
      default: begin
      end
    endcase
  end

  // busy whenever the sequencer is off its idle step
  assign busy       = (pc_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

/* rtl/lpht_checker.sv */
module lpht_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [lpht_pkg::STAT_W-1:0] out_status,
  input logic [lpht_pkg::SLOT_W-1:0] out_slot
);

  import lpht_pkg::*;

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result only shows once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a transaction");

  // one strobe per transaction, never two back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // failed or rejected transactions report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_slot == '0))
    else $error("nonzero slot on a failed transaction");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);

/* test/linear_probe_hash_table_top_tb.sv */
module linear_probe_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;
  localparam logic [MOD_W-1:0] PHASE_MOD [8] = '{7'd1, 7'd127, 7'd64, 7'd0,
                                                  7'd61, 7'd2, 7'd33, 7'd96};

  // mirror of the key store and the modulus register, plus the queue of
  // outcomes still owed by the block
  class table_mirror;
    typedef struct {
      logic              cmd;
      logic [KEY_W-1:0]  key;
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
    } outcome_t;

    logic [KEY_W-1:0] keys [TABLE_SIZE];
    logic [MOD_W-1:0] modulus;
    outcome_t owed [$];
    int mismatches;
    int checked;
    int by_status [4];

    function new();
      foreach (keys[i]) keys[i] = '0;
      foreach (by_status[i]) by_status[i] = 0;
      modulus = MOD_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_modulus(logic [MOD_W-1:0] v);
      modulus = v;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (keys[i]) if (keys[i] != '0) n++;
      return n;
    endfunction

    // pick one of the stored keys, spread by the caller's random number
    function logic [KEY_W-1:0] stored_key(int unsigned pick);
      int target;
      int n;
      target = pick % used_slots();
      n = 0;
      foreach (keys[i]) begin
        if (keys[i] != '0) begin
          if (n == target) return keys[i];
          n++;
        end
      end
      return '0;
    endfunction

    // hash, probe and update the store exactly as the block must
    function void note_command(logic cmd, logic [KEY_W-1:0] key);
      outcome_t o;
      int unsigned sum;
      int unsigned divisor;
      int unsigned pos;
      bit done;
      o.cmd = cmd;
      o.key = key;
      o.status = ST_OK;
      o.slot = '0;
      sum = 0;
      done = 0;
      for (int b = 0; b < 8; b++) sum += key[8*b +: 8];
      divisor = (modulus == 0) ? 1 : modulus;
      pos = (sum % divisor) % TABLE_SIZE;
      if (key == '0) begin
        o.status = ST_ZERO;
        done = 1;
      end
      for (int n = 0; n < TABLE_SIZE && !done; n++) begin
        if (cmd == CMD_INSERT && keys[pos] == '0) begin
          keys[pos] = key;
          o.slot = pos[SLOT_W-1:0];
          done = 1;
        end else if (cmd == CMD_LOOKUP && keys[pos] == key) begin
          o.slot = pos[SLOT_W-1:0];
          done = 1;
        end else if (cmd == CMD_LOOKUP && keys[pos] == '0) begin
          o.status = ST_MISS;
          done = 1;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
      if (!done) o.status = (cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
      owed.push_back(o);
    endfunction

    function void check_outcome(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot);
      outcome_t o;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing owed: status %0d slot %0d", $realtime,
                   status, slot);
        return;
      end
      o = owed.pop_front();
      checked++;
      by_status[o.status]++;
      if (status !== o.status || slot !== o.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: cmd %0d key %h: expected status %0d slot %0d, got status %0d slot %0d",
                   $realtime, o.cmd, o.key, o.status, o.slot, status, slot);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_cmd = 1'b0;
  logic [KEY_W-1:0]    in_key_bytes = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                cfg_we = 1'b0;
  logic [MOD_W-1:0]    cfg_wdata = '0;

  table_mirror mirror = new();
  int max_gap = 4;
  int items_sent = 0;
  int mod_writes = 0;

  linear_probe_hash_table_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_key_bytes (in_key_bytes),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every result strobe is a transaction; compare it with the oldest owed outcome
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) mirror.check_outcome(out_status, out_slot);
  end

  // one transaction: optional idle cycles with junk on the inputs, then start
  // held high until an edge sees busy low
  task automatic send(input logic cmd, input logic [KEY_W-1:0] key);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        in_cmd = 1'($urandom);
        in_key_bytes = {$urandom, $urandom};
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_cmd = cmd;
    in_key_bytes = key;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.note_command(cmd, key);
    items_sent++;
  endtask

  // drop start and wait until the block is idle with nothing owed
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (mirror.owed.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] v);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    mirror.set_modulus(v);
    cfg_we = 1'b0;
    cfg_wdata = MOD_W'($urandom);
    mod_writes++;
  endtask

  // key mix: zero, fully random, already stored, short clustered, random length
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int r;
    int len;
    k = '0;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      k = '0;
    end else if (r < 13) begin
      k = {$urandom, $urandom};
    end else if (r < 38 && mirror.used_slots() > 0) begin
      k = mirror.stored_key($urandom);
    end else if (r < 50) begin
      // one small byte anywhere: lots of home slot collisions
      k[7:0] = 8'($urandom_range(1, 12));
      k = k << (8 * $urandom_range(0, 7));
    end else begin
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    end
    return k;
  endfunction

  task automatic random_item(input int insert_pct);
    send(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP, pick_key());
  endtask

  initial begin
    int waited;
    logic [MOD_W-1:0] m;

    // reset first, then the block clears its store on its own
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset modulus 61 first
    send(CMD_LOOKUP, 64'h41);                   // lookup in an empty table
    send(CMD_INSERT, 64'h0);                    // zero key, both commands
    send(CMD_LOOKUP, 64'h0);
    send(CMD_INSERT, '1);                       // largest key
    send(CMD_INSERT, '1);                       // duplicate goes one slot further
    send(CMD_LOOKUP, '1);
    send(CMD_INSERT, 64'h1);
    send(CMD_INSERT, 64'h0100_0000_0000_0000);  // same sum from the top byte
    send(CMD_LOOKUP, 64'h0100_0000_0000_0000);
    send(CMD_LOOKUP, 64'h0000_0000_0000_0100);  // same home, not stored
    send(CMD_INSERT, 64'h3d);
    send(CMD_INSERT, 64'h3c);

    // modulus above table size: home slot wraps
    write_modulus(7'd127);
    send(CMD_INSERT, 64'h3f);
    send(CMD_INSERT, 64'h3f00);                 // probe wraps past the last slot
    send(CMD_LOOKUP, 64'h3f00);
    send(CMD_LOOKUP, 64'h7e);
    send(CMD_INSERT, 64'h7f7f);

    // zero modulus behaves as one
    write_modulus(7'd0);
    send(CMD_INSERT, 64'h0505);
    send(CMD_LOOKUP, 64'h0505);

    write_modulus(7'd64);
    send(CMD_INSERT, 64'hffff);
    send(CMD_LOOKUP, 64'hffff);

    // random phases, mostly lookups so the table fills slowly over the run;
    // every third phase runs back to back with no idle cycles
    for (int p = 0; p < PHASES; p++) begin
      m = (p < 8) ? PHASE_MOD[p] : 7'($urandom_range(0, 127));
      write_modulus(m);
      max_gap = (p % 3 == 2) ? 0 : 4;
      repeat (PHASE_ITEMS) random_item(4);
    end

    // fill the table, then hammer it while full
    write_modulus(7'($urandom_range(0, 127)));
    max_gap = 4;
    while (mirror.used_slots() < TABLE_SIZE) random_item(70);
    repeat (60) random_item(50);

    // drain the outstanding results
    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (mirror.owed.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (mirror.owed.size() != 0) begin
      $display("%0d results never arrived", mirror.owed.size());
      mirror.mismatches += mirror.owed.size();
    end

    $display("%0d transactions over %0d modulus settings, %0d results checked, %0d mismatches",
             items_sent, mod_writes + 1, mirror.checked, mirror.mismatches);
    $display("stored/found %0d, not found %0d, table full %0d, zero key %0d, %0d slots in use",
             mirror.by_status[ST_OK], mirror.by_status[ST_MISS], mirror.by_status[ST_FULL],
             mirror.by_status[ST_ZERO], mirror.used_slots());
    if (mirror.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table_top.sv
rtl/lpht_checker.sv
test/linear_probe_hash_table_top_tb.sv
